// ===== sv/buddy_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Implication and next-cycle checks, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bba: same-cycle check failed");
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bba: next-cycle check failed");
`else
`define BBA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Field widths, request and status codes, datapath operations and helpers.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int REQ_W  = 11;
    localparam int OFF_W  = 10;
    localparam int SIZE_W = 11;
    localparam int LVL_W  = 5;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOM = 1'b1;

    typedef logic [LVL_W-1:0] t_lvl;
    typedef logic [2:0]       t_op;

    localparam t_op OP_NONE  = 3'd0;
    localparam t_op OP_LOAD  = 3'd1;
    localparam t_op OP_PICK  = 3'd2;
    localparam t_op OP_TAKE  = 3'd3;
    localparam t_op OP_SPLIT = 3'd4;
    localparam t_op OP_MERGE = 3'd5;
    localparam t_op OP_PLACE = 3'd6;
    localparam t_op OP_EMIT  = 3'd7;

    typedef struct packed {
        logic too_big;      // rounded request exceeds the pool
        logic found;        // some level at or above the request has a free block
        logic lvl_gt_want;  // current level still above the requested level
        logic split_more;   // one more split after this one
        logic can_merge;    // buddy at the current level is free
    } t_dp_stat;

    // smallest l with 2**l >= v (0 and 1 give 0)
    function automatic t_lvl ceil_log2(input logic [REQ_W-1:0] v);
        t_lvl res;
        res = '0;
        for (int l = REQ_W; l >= 0; l--) begin
            if ((({{REQ_W{1'b0}}, 1'b1}) << l) >= {1'b0, v}) begin
                res = LVL_W'(l);
            end
        end
        return res;
    endfunction

    // position of the highest set bit (0 gives 0)
    function automatic t_lvl floor_log2(input logic [SIZE_W-1:0] v);
        t_lvl res;
        res = '0;
        for (int l = 0; l < SIZE_W; l++) begin
            if (v[l]) begin
                res = LVL_W'(l);
            end
        end
        return res;
    endfunction

endpackage

// ===== sv/bba_if.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator channels
// Request and response valid/ready channels with their payload.
// ----------------------------------------------------------------------------
interface bba_in_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [bba_pkg::REQ_W-1:0]    req_size;
    logic [bba_pkg::OFF_W-1:0]    blk_offset;
    logic [bba_pkg::SIZE_W-1:0]   blk_size;

    modport source (output valid, output func, output req_size, output blk_offset,
                    output blk_size, input ready);
    modport sink   (input valid, input func, input req_size, input blk_offset,
                    input blk_size, output ready);
endinterface

interface bba_out_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [bba_pkg::OFF_W-1:0]    out_offset;
    logic [bba_pkg::SIZE_W-1:0]   out_size;

    modport source (output valid, output status, output out_offset, output out_size,
                    input ready);
    modport sink   (input valid, input status, input out_offset, input out_size,
                    output ready);
endinterface

// ===== sv/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator controller
// Sequences one request through search, split or merge and result hand-off.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_macros.svh"

module bba_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_func,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  bba_pkg::t_dp_stat   i_stat,
    output bba_pkg::t_op        o_op
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PICK  = 3'd1;
    localparam logic [2:0] S_TAKE  = 3'd2;
    localparam logic [2:0] S_SPLIT = 3'd3;
    localparam logic [2:0] S_MERGE = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       emit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign emit        = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        o_op    = bba_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = bba_pkg::OP_LOAD;
                    n_state = (i_func == bba_pkg::FUNC_FREE) ? S_MERGE : S_PICK;
                end
            end
            S_PICK: begin
                o_op    = bba_pkg::OP_PICK;
                n_state = (i_stat.too_big || !i_stat.found) ? S_EMIT : S_TAKE;
            end
            S_TAKE: begin
                o_op    = bba_pkg::OP_TAKE;
                n_state = i_stat.lvl_gt_want ? S_SPLIT : S_EMIT;
            end
            S_SPLIT: begin
                o_op    = bba_pkg::OP_SPLIT;
                n_state = i_stat.split_more ? S_SPLIT : S_EMIT;
            end
            S_MERGE: begin
                if (i_stat.can_merge) begin
                    o_op = bba_pkg::OP_MERGE;
                end else begin
                    o_op    = bba_pkg::OP_PLACE;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit) begin
                    o_op    = bba_pkg::OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `BBA_ASSERT_NEXT(a_emit_loads_result, i_clk, i_rst_n, emit, r_out_valid && r_state == S_IDLE)
    `BBA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != S_IDLE)
    `BBA_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid)

endmodule

// ===== sv/bba_datapath.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator datapath
// Per-level free bitmaps, level and offset registers, result register.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_macros.svh"

module bba_datapath #(
    parameter int POOL_SIZE = 1024,
    parameter int MIN_BLOCK = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bba_pkg::t_op                 i_op,
    input  logic                         i_func,
    input  logic [bba_pkg::REQ_W-1:0]    i_req_size,
    input  logic [bba_pkg::OFF_W-1:0]    i_blk_offset,
    input  logic [bba_pkg::SIZE_W-1:0]   i_blk_size,
    output bba_pkg::t_dp_stat            o_stat,
    output logic                         o_status,
    output logic [bba_pkg::OFF_W-1:0]    o_out_offset,
    output logic [bba_pkg::SIZE_W-1:0]   o_out_size
);

    localparam int LVL_W   = bba_pkg::LVL_W;
    localparam int TOP_LVL = $clog2(POOL_SIZE + 1) - 1;
    localparam int MIN_RAW = $clog2(MIN_BLOCK);
    localparam int MIN_LVL = (MIN_RAW > TOP_LVL) ? TOP_LVL : MIN_RAW;
    localparam int NLVL    = TOP_LVL - MIN_LVL + 1;
    localparam int IW      = (TOP_LVL > MIN_LVL) ? (TOP_LVL - MIN_LVL) : 1;
    localparam int NW      = 1 << IW;
    localparam int RW      = (NLVL > 1) ? $clog2(NLVL) : 1;
    localparam int OW      = TOP_LVL;

    localparam bba_pkg::t_lvl TOP_L = LVL_W'(TOP_LVL);
    localparam bba_pkg::t_lvl MIN_L = LVL_W'(MIN_LVL);

    // one row per level, lowest level first; row bit i is block i of that level
    logic [NW-1:0]             r_map [NLVL];
    logic                      r_func, n_func;
    logic                      r_fail, n_fail;
    bba_pkg::t_lvl             r_want, n_want;
    bba_pkg::t_lvl             r_lvl, n_lvl;
    logic [OW-1:0]             r_off, n_off;
    logic                      r_res_status;
    logic [bba_pkg::OFF_W-1:0] r_res_off;
    logic [bba_pkg::SIZE_W-1:0] r_res_size;

    logic [RW-1:0]   row_cur;
    logic [NW-1:0]   row_data;
    logic [IW-1:0]   idx_cur;
    logic [IW-1:0]   idx_buddy;
    logic [IW-1:0]   idx_low;
    logic            found;
    bba_pkg::t_lvl   pick_lvl;
    bba_pkg::t_lvl   want_raw;
    bba_pkg::t_lvl   free_raw;
    bba_pkg::t_lvl   free_lvl;
    bba_pkg::t_lvl   lvl_dn;
    logic [OW-1:0]   in_off;

    logic            wr_en;
    logic [RW-1:0]   wr_row;
    logic [IW-1:0]   wr_idx;
    logic            wr_val;

    assign lvl_dn    = r_lvl - LVL_W'(1);
    assign row_cur   = RW'(r_lvl - MIN_L);
    assign row_data  = r_map[row_cur];
    assign idx_cur   = IW'(r_off >> r_lvl);
    assign idx_buddy = idx_cur ^ IW'(1);

    assign o_stat.too_big     = (r_want > TOP_L);
    assign o_stat.found       = found;
    assign o_stat.lvl_gt_want = (r_lvl > r_want);
    assign o_stat.split_more  = (lvl_dn > r_want);
    assign o_stat.can_merge   = (r_lvl < TOP_L) && row_data[idx_buddy];

    // smallest level at or above the request that holds a free block
    always_comb begin
        found    = 1'b0;
        pick_lvl = r_want;
        for (int r = NLVL - 1; r >= 0; r--) begin
            if ((|r_map[r]) && (LVL_W'(r + MIN_LVL) >= r_want)) begin
                found    = 1'b1;
                pick_lvl = LVL_W'(r + MIN_LVL);
            end
        end
    end

    // lowest free block in the current level
    always_comb begin
        idx_low = '0;
        for (int i = NW - 1; i >= 0; i--) begin
            if (row_data[i]) begin
                idx_low = IW'(i);
            end
        end
    end

    always_comb begin
        want_raw = bba_pkg::ceil_log2(i_req_size);
        if (want_raw < MIN_L) begin
            want_raw = MIN_L;
        end
        free_raw = bba_pkg::floor_log2(i_blk_size);
        free_lvl = free_raw;
        if (free_raw < MIN_L) begin
            free_lvl = MIN_L;
        end else if (free_raw > TOP_L) begin
            free_lvl = TOP_L;
        end
        in_off = OW'(i_blk_offset) & ~((OW'(1) << free_lvl) - OW'(1));
    end

    always_comb begin
        n_func = r_func;
        n_fail = r_fail;
        n_want = r_want;
        n_lvl  = r_lvl;
        n_off  = r_off;
        wr_en  = 1'b0;
        wr_row = row_cur;
        wr_idx = idx_cur;
        wr_val = 1'b0;
        unique case (i_op) inside
            bba_pkg::OP_LOAD: begin
                n_func = i_func;
                n_fail = 1'b0;
                n_want = want_raw;
                n_lvl  = free_lvl;
                n_off  = in_off;
            end
            bba_pkg::OP_PICK: begin
                n_fail = (r_want > TOP_L) || !found;
                n_lvl  = pick_lvl;
            end
            bba_pkg::OP_TAKE: begin
                n_off  = OW'(idx_low) << r_lvl;
                wr_en  = 1'b1;
                wr_idx = idx_low;
                wr_val = 1'b0;
            end
            bba_pkg::OP_SPLIT: begin
                // free the upper half one level down, keep the lower half
                n_lvl  = lvl_dn;
                wr_en  = 1'b1;
                wr_row = RW'(lvl_dn - MIN_L);
                wr_idx = IW'(r_off >> lvl_dn) | IW'(1);
                wr_val = 1'b1;
            end
            bba_pkg::OP_MERGE: begin
                n_lvl  = r_lvl + LVL_W'(1);
                n_off  = r_off & ~(OW'(1) << r_lvl);
                wr_en  = 1'b1;
                wr_idx = idx_buddy;
                wr_val = 1'b0;
            end
            bba_pkg::OP_PLACE: begin
                wr_en  = 1'b1;
                wr_val = 1'b1;
            end
            bba_pkg::OP_NONE, bba_pkg::OP_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // only the whole-pool block starts free
            for (int r = 0; r < NLVL; r++) begin
                r_map[r] <= (r == NLVL - 1) ? NW'(1) : '0;
            end
        end else if (wr_en) begin
            r_map[wr_row][wr_idx] <= wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_fail <= n_fail;
        r_want <= n_want;
        r_lvl  <= n_lvl;
        r_off  <= n_off;
        if (i_op == bba_pkg::OP_EMIT) begin
            r_res_status <= r_fail ? bba_pkg::STATUS_OOM : bba_pkg::STATUS_OK;
            if ((r_func == bba_pkg::FUNC_FREE) || r_fail) begin
                r_res_off  <= '0;
                r_res_size <= '0;
            end else begin
                r_res_off  <= bba_pkg::OFF_W'(r_off);
                r_res_size <= (r_want < LVL_W'(bba_pkg::SIZE_W))
                            ? (bba_pkg::SIZE_W'(1) << r_want) : '0;
            end
        end
    end

    assign o_status     = r_res_status;
    assign o_out_offset = r_res_off;
    assign o_out_size   = r_res_size;

    `BBA_ASSERT_NEXT(a_split_descends, i_clk, i_rst_n, i_op == bba_pkg::OP_SPLIT, r_lvl == $past(r_lvl) - LVL_W'(1))
    `BBA_ASSERT_IMPL(a_split_above_want, i_clk, i_rst_n, i_op == bba_pkg::OP_SPLIT, r_lvl > r_want)
    `BBA_ASSERT_IMPL(a_merge_below_top, i_clk, i_rst_n, i_op == bba_pkg::OP_MERGE, r_lvl < TOP_L)
    `BBA_ASSERT_IMPL(a_take_has_block, i_clk, i_rst_n, i_op == bba_pkg::OP_TAKE, |row_data)

endmodule

// ===== sv/buddy_block_allocator.sv =====
// Buddy allocator over a POOL_SIZE pool with MIN_BLOCK smallest blocks. One
// request is in work at a time; a new one is accepted once the previous one
// has reached the result register, which may still be waiting on o_out.ready.
// An allocate picks a free block, takes it and makes s splits, s being the
// number of levels from the level where it was found down to the request;
// a failed allocate goes from the pick straight to the result. A free makes
// m buddy merges and then places the block. Both walks step one level per
// cycle through the per-level free bitmaps (six levels in the default pool).
// Freed blocks are not checked against what was allocated.
// ----------------------------------------------------------------------------
// Buddy block allocator top level
// Controller and bitmap datapath behind valid/ready request and response.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
    parameter int POOL_SIZE = 1024,
    parameter int MIN_BLOCK = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bba_in_if.sink     i_in,
    bba_out_if.source  o_out
);

    bba_pkg::t_op      op;
    bba_pkg::t_dp_stat stat;

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_func      (i_in.func),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_op        (op)
    );

    bba_datapath #(
        .POOL_SIZE (POOL_SIZE),
        .MIN_BLOCK (MIN_BLOCK)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_func       (i_in.func),
        .i_req_size   (i_in.req_size),
        .i_blk_offset (i_in.blk_offset),
        .i_blk_size   (i_in.blk_size),
        .o_stat       (stat),
        .o_status     (o_out.status),
        .o_out_offset (o_out.out_offset),
        .o_out_size   (o_out.out_size)
    );

endmodule
